>>> hdl/sfti_pkg.sv
// Shared types, codes and constants of the strip and fan to triangle converter.
package sfti_pkg;

	localparam int DEF_MAX_WORDS    = 16384;
	localparam int DEF_HASH_SIZE    = 16384;
	localparam int DEF_MAX_SOURCES  = 2048;
	localparam int DEF_VERTEX_DEPTH = 8192;

	localparam logic [31:0] HASH_MULT = 32'd2654435761;
	localparam logic signed [31:0] COUNT_MAX = 32'sd65535;
	localparam logic signed [31:0] COUNT_MIN = -32'sd65535;
	localparam logic [16:0] MIN_VERTS = 17'd3;

	typedef logic [1:0]  kind_t;
	typedef logic [12:0] ri_t;
	typedef logic [10:0] si_t;
	typedef logic [2:0]  err_t;
	typedef logic [13:0] vc_t;
	typedef logic [14:0] ic_t;
	typedef logic [0:0]  cfg_idx_t;
	typedef logic [14:0] cfg_data_t;

	localparam kind_t KIND_CORNER = 2'd0;
	localparam kind_t KIND_DONE   = 2'd1;
	localparam kind_t KIND_ERROR  = 2'd2;

	localparam err_t ERR_NONE      = 3'd0;
	localparam err_t ERR_COUNT     = 3'd1;
	localparam err_t ERR_SHORT     = 3'd2;
	localparam err_t ERR_TRUNC     = 3'd3;
	localparam err_t ERR_SOURCE    = 3'd4;
	localparam err_t ERR_NO_END    = 3'd5;

	localparam cfg_idx_t REG_TOTAL_WORDS  = 1'd0;
	localparam cfg_idx_t REG_SOURCE_COUNT = 1'd1;

	localparam logic [1:0] PH_COUNT = 2'd0;
	localparam logic [1:0] PH_S     = 2'd1;
	localparam logic [1:0] PH_T     = 2'd2;
	localparam logic [1:0] PH_SRC   = 2'd3;

	typedef struct packed {
		kind_t kind;
		ri_t   render_index;
		si_t   source_index;
		err_t  error_code;
		vc_t   vertex_count;
		ic_t   index_count;
		logic  last;
	} result_t;

	typedef struct packed {
		logic accept;
		logic hash_start;
		logic slot_read;
		logic vert_read;
		logic probe_next;
		logic found;
		logic insert;
		logic emit;
		logic fail_src;
		logic fail_full;
		logic clear_sweep;
	} cmd_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       out_empty;
		logic       count_fin;
		logic       src_bad;
		logic       slot_empty;
		logic       match;
		logic       probe_last;
		logic       vstore_full;
		logic       emit_fin;
		logic       clear_last;
	} sts_t;

endpackage

>>> hdl/sfti_ctrl.sv
// Sequencer: word intake, hash probing, insertion, corner emission and table clearing.
module sfti_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          word_valid,
	output logic          word_stall,
	input  sfti_pkg::sts_t sts,
	output sfti_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_SLOT  = 3'd4;
	localparam logic [2:0] ST_CMP   = 3'd5;
	localparam logic [2:0] ST_INS   = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       ready;

	assign ready = (state_q == ST_IDLE) &&
		(sts.phase == sfti_pkg::PH_S || sts.phase == sfti_pkg::PH_T || sts.out_empty);
	assign word_stall = !ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_sweep = 1'b1;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (word_valid && ready) begin
					cmd.accept = 1'b1;
					if (sts.phase == sfti_pkg::PH_COUNT && sts.count_fin) state_d = ST_CLEAR;
					else if (sts.phase == sfti_pkg::PH_SRC) state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (sts.src_bad) begin
					cmd.fail_src = 1'b1;
					state_d = ST_CLEAR;
				end else begin
					cmd.hash_start = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				cmd.slot_read = 1'b1;
				state_d = ST_SLOT;
			end
			ST_SLOT: begin
				if (sts.slot_empty) state_d = ST_INS;
				else begin
					cmd.vert_read = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.match) begin
					cmd.found = 1'b1;
					state_d = ST_EMIT;
				end else if (sts.probe_last) begin
					cmd.fail_full = 1'b1;
					state_d = ST_CLEAR;
				end else begin
					cmd.probe_next = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_INS: begin
				if (sts.vstore_full) begin
					cmd.fail_full = 1'b1;
					state_d = ST_CLEAR;
				end else begin
					cmd.insert = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = sts.emit_fin ? ST_CLEAR : ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

endmodule

>>> hdl/sfti_dp.sv
// Datapath: config registers, stream state, hash and vertex stores, result buffer.
module sfti_dp #(
	parameter int MAX_WORDS    = sfti_pkg::DEF_MAX_WORDS,
	parameter int HASH_SIZE    = sfti_pkg::DEF_HASH_SIZE,
	parameter int MAX_SOURCES  = sfti_pkg::DEF_MAX_SOURCES,
	parameter int VERTEX_DEPTH = sfti_pkg::DEF_VERTEX_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  sfti_pkg::cfg_idx_t   cfg_index,
	input  sfti_pkg::cfg_data_t  cfg_data,
	input  logic signed [31:0]   word,
	input  sfti_pkg::cmd_t       cmd,
	output sfti_pkg::sts_t       sts,
	output logic                 result_valid,
	input  logic                 result_stall,
	output sfti_pkg::result_t    result
);

	localparam int WW      = $clog2(MAX_WORDS + 1);
	localparam int PLW     = $clog2(MAX_WORDS / 3 + 1);
	localparam int HASH_AW = $clog2(HASH_SIZE + 1) - 1;
	localparam int HD      = 2 ** HASH_AW;
	localparam int SRCW    = $clog2(MAX_SOURCES);
	localparam int VAW     = $clog2(VERTEX_DEPTH);
	localparam int VCW     = $clog2(VERTEX_DEPTH + 1);
	localparam int SMW     = (WW > HASH_AW) ? WW : HASH_AW;

	// config
	logic [14:0] total_q;
	logic [11:0] source_q;
	logic [HASH_AW-1:0] mask_q;

	// stream state
	logic [1:0]         phase_q;
	logic [WW-1:0]      wu_q;
	logic [PLW-1:0]     plen_q, ppos_q;
	logic               fan_q;
	logic [VCW-1:0]     unique_q;
	logic [14:0]        ind_q;
	logic [HASH_AW-1:0] clr_q, probe_q;
	logic [1:0]         out_n_q, out_ptr_q;

	logic [31:0]        tex_s_q, tex_t_q, part_q, prod_q, w_q;
	logic               src_bad_q;
	logic [HASH_AW-1:0] h_q;
	logic [VCW-1:0]     slot_q;
	logic [SRCW+63:0]   vdata_q;
	logic [VAW-1:0]     idx_q, first_q, prev_q, bef_q;
	logic [SRCW-1:0]    first_src_q, prev_src_q, bef_src_q;
	sfti_pkg::result_t  out_q [3];

	logic [VCW-1:0]     hash_mem [HD];
	logic [SRCW+63:0]   vert_mem [VERTEX_DEPTH];

	// effective registers and table mask
	logic [16:0]        tw17, eff17;
	logic [WW-1:0]      eff_total;
	logic [12:0]        src13, eff_src;
	logic [SMW-1:0]     em1, sm;
	logic [HASH_AW-1:0] mask_d;

	always_comb begin
		tw17 = 17'(total_q);
		eff17 = (tw17 < 17'(MAX_WORDS)) ? tw17 : 17'(MAX_WORDS);
		eff_total = eff17[WW-1:0];
		src13 = 13'(source_q);
		eff_src = (src13 < 13'(MAX_SOURCES)) ? src13 : 13'(MAX_SOURCES);
		em1 = SMW'(eff_total) - 1'b1;
		for (int i = 0; i < SMW; i++) sm[i] = |(em1 >> i);
		mask_d = (eff_total <= WW'(1)) ? '0 : sm[HASH_AW-1:0];
	end

	// count word checks
	logic [WW-1:0]  wu_inc, rem;
	logic [31:0]    neg_w;
	logic [16:0]    mag;
	logic [17:0]    mag3;
	logic           no_words, is_zero, range_bad, too_short, trunc, count_fin;

	always_comb begin
		wu_inc = wu_q + 1'b1;
		rem = eff_total - wu_inc;
		neg_w = 32'd0 - $unsigned(word);
		mag = word[31] ? neg_w[16:0] : word[16:0];
		mag3 = 18'(mag) + (18'(mag) << 1);
		no_words = wu_q >= eff_total;
		is_zero = (word == 32'sd0);
		range_bad = (word < sfti_pkg::COUNT_MIN) || (word > sfti_pkg::COUNT_MAX);
		too_short = mag < sfti_pkg::MIN_VERTS;
		trunc = mag3 > 18'(rem);
		count_fin = no_words || is_zero || range_bad || too_short || trunc;
	end

	// hash and probing
	logic [31:0]        h32, hf;
	logic [VCW-1:0]     slot_m1;
	logic [PLW-1:0]     pnext;
	logic               emit_fin, match;

	always_comb begin
		h32 = part_q + prod_q;
		hf = h32 ^ (h32 >> 16);
		slot_m1 = slot_q - 1'b1;
		pnext = ppos_q + 1'b1;
		emit_fin = (pnext >= plen_q) && (wu_q >= eff_total);
		match = vdata_q == {w_q[SRCW-1:0], tex_t_q, tex_s_q};
	end

	// finishing
	logic                fin;
	sfti_pkg::kind_t     fin_kind;
	sfti_pkg::err_t      fin_err;

	always_comb begin
		fin = (cmd.accept && phase_q == sfti_pkg::PH_COUNT && count_fin) ||
			cmd.fail_src || cmd.fail_full || (cmd.emit && emit_fin);
		fin_kind = sfti_pkg::KIND_ERROR;
		fin_err = sfti_pkg::ERR_NO_END;
		if (cmd.accept) begin
			if (no_words) fin_err = sfti_pkg::ERR_NO_END;
			else if (is_zero) begin
				fin_kind = sfti_pkg::KIND_DONE;
				fin_err = sfti_pkg::ERR_NONE;
			end else if (range_bad) fin_err = sfti_pkg::ERR_COUNT;
			else if (too_short) fin_err = sfti_pkg::ERR_SHORT;
			else fin_err = sfti_pkg::ERR_TRUNC;
		end else if (cmd.fail_src) fin_err = sfti_pkg::ERR_SOURCE;
		else if (cmd.fail_full) fin_err = sfti_pkg::ERR_TRUNC;
	end

	// corner selection
	logic               corners, odd;
	logic [VAW-1:0]     ca, cb;
	logic [SRCW-1:0]    sa, sb;

	always_comb begin
		corners = cmd.emit && !emit_fin && (ppos_q >= PLW'(2));
		odd = ppos_q[0];
		ca = fan_q ? first_q : (odd ? prev_q : bef_q);
		sa = fan_q ? first_src_q : (odd ? prev_src_q : bef_src_q);
		cb = fan_q ? prev_q : (odd ? bef_q : prev_q);
		sb = fan_q ? prev_src_q : (odd ? bef_src_q : prev_src_q);
	end

	logic pop;
	assign result_valid = out_n_q != 2'd0;
	assign result = out_q[out_ptr_q];
	assign pop = result_valid && !result_stall;

	assign sts.phase = phase_q;
	assign sts.out_empty = out_n_q == 2'd0;
	assign sts.count_fin = count_fin;
	assign sts.src_bad = src_bad_q;
	assign sts.slot_empty = slot_q == '0;
	assign sts.match = match;
	assign sts.probe_last = probe_q == mask_q;
	assign sts.vstore_full = unique_q >= VCW'(VERTEX_DEPTH);
	assign sts.emit_fin = emit_fin;
	assign sts.clear_last = &clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 15'd1;
			source_q <= 12'd1;
			mask_q <= '0;
			phase_q <= sfti_pkg::PH_COUNT;
			wu_q <= '0;
			plen_q <= '0;
			ppos_q <= '0;
			fan_q <= 1'b0;
			unique_q <= '0;
			ind_q <= '0;
			clr_q <= '0;
			probe_q <= '0;
			out_n_q <= 2'd0;
			out_ptr_q <= 2'd0;
		end else begin
			mask_q <= mask_d;
			if (cfg_valid) begin
				if (cfg_index == sfti_pkg::REG_TOTAL_WORDS) total_q <= cfg_data;
				else if (cfg_index == sfti_pkg::REG_SOURCE_COUNT) source_q <= cfg_data[11:0];
			end
			if (cmd.clear_sweep) clr_q <= clr_q + 1'b1;
			if (cmd.hash_start) probe_q <= '0;
			else if (cmd.probe_next) probe_q <= probe_q + 1'b1;
			if (cmd.insert) unique_q <= unique_q + 1'b1;
			if (cmd.accept) begin
				wu_q <= wu_inc;
				case (phase_q)
					sfti_pkg::PH_COUNT: begin
						fan_q <= word[31];
						plen_q <= mag[PLW-1:0];
						ppos_q <= '0;
						phase_q <= sfti_pkg::PH_S;
					end
					sfti_pkg::PH_S: phase_q <= sfti_pkg::PH_T;
					sfti_pkg::PH_T: phase_q <= sfti_pkg::PH_SRC;
					default: phase_q <= sfti_pkg::PH_S;
				endcase
			end
			if (cmd.emit) begin
				ppos_q <= pnext;
				if (pnext >= plen_q) phase_q <= sfti_pkg::PH_COUNT;
			end
			if (corners) ind_q <= ind_q + 15'd3;
			if (fin || corners) begin
				out_n_q <= fin ? 2'd1 : 2'd3;
				out_ptr_q <= 2'd0;
			end else if (pop) begin
				out_n_q <= out_n_q - 1'b1;
				out_ptr_q <= out_ptr_q + 1'b1;
			end
			if (fin) begin
				phase_q <= sfti_pkg::PH_COUNT;
				wu_q <= '0;
				plen_q <= '0;
				ppos_q <= '0;
				fan_q <= 1'b0;
				unique_q <= '0;
				ind_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			w_q <= word;
			prod_q <= $unsigned(word) * sfti_pkg::HASH_MULT;
			src_bad_q <= $unsigned(word) >= 32'(eff_src);
			if (phase_q == sfti_pkg::PH_S) tex_s_q <= word;
			if (phase_q == sfti_pkg::PH_T) begin
				tex_t_q <= word;
				part_q <= ((tex_s_q << 5) - tex_s_q) + (($unsigned(word) << 4) + $unsigned(word));
			end
		end
		if (cmd.hash_start) h_q <= hf[HASH_AW-1:0] & mask_q;
		else if (cmd.probe_next) h_q <= (h_q + 1'b1) & mask_q;
		if (cmd.found) idx_q <= slot_m1[VAW-1:0];
		else if (cmd.insert) idx_q <= unique_q[VAW-1:0];
		if (cmd.emit) begin
			if (ppos_q == '0) begin
				first_q <= idx_q;
				first_src_q <= w_q[SRCW-1:0];
			end
			bef_q <= prev_q;
			bef_src_q <= prev_src_q;
			prev_q <= idx_q;
			prev_src_q <= w_q[SRCW-1:0];
		end
		if (fin) begin
			out_q[0] <= '{kind: fin_kind, render_index: '0, source_index: '0,
				error_code: fin_err, vertex_count: sfti_pkg::vc_t'(unique_q),
				index_count: ind_q, last: 1'b1};
		end else if (corners) begin
			out_q[0] <= '{kind: sfti_pkg::KIND_CORNER, render_index: sfti_pkg::ri_t'(ca),
				source_index: sfti_pkg::si_t'(sa), error_code: sfti_pkg::ERR_NONE,
				vertex_count: sfti_pkg::vc_t'(unique_q), index_count: ind_q + 15'd1,
				last: 1'b0};
			out_q[1] <= '{kind: sfti_pkg::KIND_CORNER, render_index: sfti_pkg::ri_t'(cb),
				source_index: sfti_pkg::si_t'(sb), error_code: sfti_pkg::ERR_NONE,
				vertex_count: sfti_pkg::vc_t'(unique_q), index_count: ind_q + 15'd2,
				last: 1'b0};
			out_q[2] <= '{kind: sfti_pkg::KIND_CORNER, render_index: sfti_pkg::ri_t'(idx_q),
				source_index: sfti_pkg::si_t'(w_q[SRCW-1:0]),
				error_code: sfti_pkg::ERR_NONE, vertex_count: sfti_pkg::vc_t'(unique_q),
				index_count: ind_q + 15'd3, last: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_sweep) hash_mem[clr_q] <= '0;
		else if (cmd.insert) hash_mem[h_q] <= unique_q + 1'b1;
		if (cmd.slot_read) slot_q <= hash_mem[h_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) vert_mem[unique_q[VAW-1:0]] <= {w_q[SRCW-1:0], tex_t_q, tex_s_q};
		if (cmd.vert_read) vdata_q <= vert_mem[slot_m1[VAW-1:0]];
	end

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> unique_q < VCW'(VERTEX_DEPTH))
		else $error("vertex insert with store full");
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fin || corners) |-> out_n_q == 2'd0)
		else $error("result buffer loaded while not empty");
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> phase_q == sfti_pkg::PH_COUNT && unique_q == '0 && out_n_q == 2'd1)
		else $error("stream not cleared after finish");
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_next |-> probe_q != mask_q)
		else $error("probe beyond table size");

endmodule

>>> hdl/strip_fan_to_indexed_triangles.sv
// A vertex word goes through hash, slot read, slot check, compare or insert, and emit;
// each extra probe repeats slot read, slot check and compare. Up to three corner items
// drain one per cycle unless stalled, overlapping the next s and t words.
// Reset and every done or error item clear all 2**floor(log2(HASH_SIZE)) hash entries,
// during which no word is taken; config regs reset to 1.
module strip_fan_to_indexed_triangles #(
	parameter int MAX_WORDS    = sfti_pkg::DEF_MAX_WORDS,
	parameter int HASH_SIZE    = sfti_pkg::DEF_HASH_SIZE,
	parameter int MAX_SOURCES  = sfti_pkg::DEF_MAX_SOURCES,
	parameter int VERTEX_DEPTH = sfti_pkg::DEF_VERTEX_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  sfti_pkg::cfg_idx_t  cfg_index,
	input  sfti_pkg::cfg_data_t cfg_data,
	input  logic                word_valid,
	output logic                word_stall,
	input  logic signed [31:0]  word,
	output logic                result_valid,
	input  logic                result_stall,
	output sfti_pkg::kind_t     kind,
	output sfti_pkg::ri_t       render_index,
	output sfti_pkg::si_t       source_index,
	output sfti_pkg::err_t      error_code,
	output sfti_pkg::vc_t       vertex_count,
	output sfti_pkg::ic_t       index_count,
	output logic                last
);

	sfti_pkg::cmd_t    cmd;
	sfti_pkg::sts_t    sts;
	sfti_pkg::result_t result;

	assign cfg_ready = 1'b1;

	sfti_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	sfti_dp #(
		.MAX_WORDS    (MAX_WORDS),
		.HASH_SIZE    (HASH_SIZE),
		.MAX_SOURCES  (MAX_SOURCES),
		.VERTEX_DEPTH (VERTEX_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.word         (word),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign kind = result.kind;
	assign render_index = result.render_index;
	assign source_index = result.source_index;
	assign error_code = result.error_code;
	assign vertex_count = result.vertex_count;
	assign index_count = result.index_count;
	assign last = result.last;

endmodule
